// File: rtl/core/sgd_pkg.sv
// Shared types, register indexes and reset values for the shake gesture detector.
package sgd_pkg;

  localparam int unsigned AXIS_W = 16;
  localparam int unsigned ABS_W  = 17;
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 3;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] CFG_HIGH_THRESHOLD      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_LOW_THRESHOLD       = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MAX_CROSSING_GAP_MS = 3'd2;
  localparam logic [IDX_W-1:0] CFG_REQUIRED_CROSSINGS  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_COOLDOWN_MS         = 3'd4;

  localparam logic [MAG_W-1:0]  RST_HIGH_THRESHOLD      = 17'd20000;
  localparam logic [MAG_W-1:0]  RST_LOW_THRESHOLD       = 17'd12000;
  localparam logic [TIME_W-1:0] RST_MAX_CROSSING_GAP_MS = 32'd300;
  localparam logic [CNT_W-1:0]  RST_REQUIRED_CROSSINGS  = 8'd4;
  localparam logic [TIME_W-1:0] RST_COOLDOWN_MS         = 32'd1000;

  typedef struct packed {
    logic [MAG_W-1:0]  high_threshold;
    logic [MAG_W-1:0]  low_threshold;
    logic [TIME_W-1:0] max_crossing_gap_ms;
    logic [CNT_W-1:0]  required_crossings;
    logic [TIME_W-1:0] cooldown_ms;
  } cfg_t;

endpackage

// File: rtl/core/shake_gesture_detector.sv
// Shake gesture detector top level: axis lanes, merge stage, tracking stage and config registers.
//
// Takes one accelerometer sample per transaction and returns exactly one
// result transaction per sample, in order. Three axis lanes take the absolute
// value of X, Y and Z in parallel, a merge stage sums them into the magnitude,
// and the tracking stage applies the cooldown window, hysteresis crossing
// count and shake decision, then holds the result in the output register.
// Samples pass the lane, merge and output registers in turn. Throughput is
// one sample per clock while out_stall is low, set by the state update in
// the tracking stage. Each stage keeps its own valid bit and fills bubbles, so
// samples keep entering while a finished result is stalled, until the pipeline is full.
// Write configuration through cfg_we/cfg_index/cfg_wdata only while the block
// is idle; indexes: 0 high_threshold, 1 low_threshold, 2 max_crossing_gap_ms,
// 3 required_crossings, 4 cooldown_ms; other indexes are ignored. All time
// differences are unsigned and wrap at 32 bits. After reset the last-shake
// time is zero, so samples stamped below cooldown_ms are reported as cooldown.
module shake_gesture_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [sgd_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sgd_pkg::CFG_W-1:0]         cfg_wdata,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sgd_pkg::AXIS_W-1:0] in_accel_x,
  input  logic signed [sgd_pkg::AXIS_W-1:0] in_accel_y,
  input  logic signed [sgd_pkg::AXIS_W-1:0] in_accel_z,
  input  logic [sgd_pkg::TIME_W-1:0]        in_time_ms,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_shake_pulse,
  output logic [sgd_pkg::MAG_W-1:0]         out_magnitude,
  output logic [sgd_pkg::CNT_W-1:0]         out_crossing_total,
  output logic                              out_in_cooldown
);

  sgd_pkg::cfg_t cfg_r;

  logic v1_r;
  logic v2_r;
  logic s1_ready;
  logic s2_ready;
  logic trk_ready;
  logic s1_load;
  logic s2_load;

  logic [sgd_pkg::TIME_W-1:0] time1_r;
  logic [sgd_pkg::TIME_W-1:0] time2_r;
  logic [sgd_pkg::ABS_W-1:0]  abs_x;
  logic [sgd_pkg::ABS_W-1:0]  abs_y;
  logic [sgd_pkg::ABS_W-1:0]  abs_z;
  logic [sgd_pkg::MAG_W-1:0]  mag;

  // Configuration registers; truncate write data to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_threshold      <= sgd_pkg::RST_HIGH_THRESHOLD;
      cfg_r.low_threshold       <= sgd_pkg::RST_LOW_THRESHOLD;
      cfg_r.max_crossing_gap_ms <= sgd_pkg::RST_MAX_CROSSING_GAP_MS;
      cfg_r.required_crossings  <= sgd_pkg::RST_REQUIRED_CROSSINGS;
      cfg_r.cooldown_ms         <= sgd_pkg::RST_COOLDOWN_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        sgd_pkg::CFG_HIGH_THRESHOLD: begin
          cfg_r.high_threshold <= cfg_wdata[sgd_pkg::MAG_W-1:0];
        end
        sgd_pkg::CFG_LOW_THRESHOLD: begin
          cfg_r.low_threshold <= cfg_wdata[sgd_pkg::MAG_W-1:0];
        end
        sgd_pkg::CFG_MAX_CROSSING_GAP_MS: begin
          cfg_r.max_crossing_gap_ms <= cfg_wdata[sgd_pkg::TIME_W-1:0];
        end
        sgd_pkg::CFG_REQUIRED_CROSSINGS: begin
          cfg_r.required_crossings <= cfg_wdata[sgd_pkg::CNT_W-1:0];
        end
        sgd_pkg::CFG_COOLDOWN_MS: begin
          cfg_r.cooldown_ms <= cfg_wdata[sgd_pkg::TIME_W-1:0];
        end
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // A stage may load when it is empty or its content moves on this cycle
  assign s2_ready = !v2_r || trk_ready;
  assign s1_ready = !v1_r || s2_ready;
  assign in_stall = !s1_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = v1_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_r <= in_valid;
      end
      if (s2_ready) begin
        v2_r <= v1_r;
      end
    end
  end

  // Carry the timestamp alongside the lane and merge stages
  always_ff @(posedge clk) begin
    if (s1_load) begin
      time1_r <= in_time_ms;
    end
    if (s2_load) begin
      time2_r <= time1_r;
    end
  end

  sgd_axis_lane u_lane_x (.clk(clk), .en(s1_load), .accel(in_accel_x), .abs_r(abs_x));
  sgd_axis_lane u_lane_y (.clk(clk), .en(s1_load), .accel(in_accel_y), .abs_r(abs_y));
  sgd_axis_lane u_lane_z (.clk(clk), .en(s1_load), .accel(in_accel_z), .abs_r(abs_z));

  sgd_merge u_merge (
    .clk   (clk),
    .en    (s2_load),
    .abs_x (abs_x),
    .abs_y (abs_y),
    .abs_z (abs_z),
    .mag_r (mag)
  );

  sgd_track u_track (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .s_valid            (v2_r),
    .s_ready            (trk_ready),
    .s_mag              (mag),
    .s_time             (time2_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shake_pulse    (out_shake_pulse),
    .out_magnitude      (out_magnitude),
    .out_crossing_total (out_crossing_total),
    .out_in_cooldown    (out_in_cooldown)
  );

endmodule

// File: rtl/core/sgd_axis_lane.sv
// One axis lane: registered absolute value of a signed accelerometer sample.
module sgd_axis_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [sgd_pkg::AXIS_W-1:0] accel,
  output logic [sgd_pkg::ABS_W-1:0]         abs_r
);

  logic [sgd_pkg::ABS_W-1:0] ext;
  logic [sgd_pkg::ABS_W-1:0] abs_nxt;

  // Sign-extend by one bit so that the most negative code negates cleanly
  assign ext     = {accel[sgd_pkg::AXIS_W-1], accel};
  assign abs_nxt = ext[sgd_pkg::ABS_W-1] ? (~ext + sgd_pkg::ABS_W'(1)) : ext;

  always_ff @(posedge clk) begin
    if (en) begin
      abs_r <= abs_nxt;
    end
  end

endmodule

// File: rtl/core/sgd_merge.sv
// Merge stage: registered sum of the three lane absolute values.
module sgd_merge (
  input  logic                       clk,
  input  logic                       en,
  input  logic [sgd_pkg::ABS_W-1:0]  abs_x,
  input  logic [sgd_pkg::ABS_W-1:0]  abs_y,
  input  logic [sgd_pkg::ABS_W-1:0]  abs_z,
  output logic [sgd_pkg::MAG_W-1:0]  mag_r
);

  logic [sgd_pkg::MAG_W-1:0] mag_nxt;

  // Largest sum is 3 * 32768, which fits the magnitude width
  assign mag_nxt = sgd_pkg::MAG_W'(abs_x) + sgd_pkg::MAG_W'(abs_y) + sgd_pkg::MAG_W'(abs_z);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

endmodule

// File: rtl/core/sgd_track.sv
// Tracking stage: cooldown, hysteresis crossing count, shake decision and result register.
module sgd_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgd_pkg::cfg_t               cfg,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic [sgd_pkg::MAG_W-1:0]   s_mag,
  input  logic [sgd_pkg::TIME_W-1:0]  s_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_shake_pulse,
  output logic [sgd_pkg::MAG_W-1:0]   out_magnitude,
  output logic [sgd_pkg::CNT_W-1:0]   out_crossing_total,
  output logic                        out_in_cooldown
);

  logic                        out_valid_r;
  logic                        above_r,       above_nxt;
  logic [sgd_pkg::CNT_W-1:0]   cnt_r,         cnt_nxt;
  logic [sgd_pkg::TIME_W-1:0]  last_cross_r,  last_cross_nxt;
  logic [sgd_pkg::TIME_W-1:0]  last_shake_r,  last_shake_nxt;

  logic                        pulse_r;
  logic [sgd_pkg::MAG_W-1:0]   mag_r;
  logic [sgd_pkg::CNT_W-1:0]   total_r;
  logic                        cool_r;

  logic                        take;
  logic                        cool;
  logic                        stale;
  logic                        up;
  logic                        dn;
  logic [sgd_pkg::CNT_W-1:0]   cnt_base;
  logic [sgd_pkg::CNT_W-1:0]   cnt_inc;
  logic                        hit;

  assign s_ready = !out_valid_r || !out_stall;
  assign take    = s_valid && s_ready;

  always_comb begin
    cool     = (s_time - last_shake_r) < cfg.cooldown_ms;
    stale    = (s_time - last_cross_r) > cfg.max_crossing_gap_ms;
    cnt_base = stale ? '0 : cnt_r;
    up       = !above_r && (s_mag > cfg.high_threshold);
    dn       = above_r && (s_mag < cfg.low_threshold);
    cnt_inc  = cnt_base + sgd_pkg::CNT_W'(up || dn);
    hit      = cnt_inc >= cfg.required_crossings;

    above_nxt      = above_r;
    cnt_nxt        = cnt_r;
    last_cross_nxt = last_cross_r;
    last_shake_nxt = last_shake_r;
    if (!cool) begin
      if (up) begin
        above_nxt = 1'b1;
      end else if (dn) begin
        above_nxt = 1'b0;
      end
      if (up || dn) begin
        last_cross_nxt = s_time;
      end
      if (hit) begin
        cnt_nxt        = '0;
        last_shake_nxt = s_time;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      above_r      <= 1'b0;
      cnt_r        <= '0;
      last_cross_r <= '0;
      last_shake_r <= '0;
    end else begin
      if (s_ready) begin
        out_valid_r <= s_valid;
      end
      if (take) begin
        above_r      <= above_nxt;
        cnt_r        <= cnt_nxt;
        last_cross_r <= last_cross_nxt;
        last_shake_r <= last_shake_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pulse_r <= !cool && hit;
      mag_r   <= s_mag;
      total_r <= cnt_nxt;
      cool_r  <= cool;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shake_pulse    = pulse_r;
  assign out_magnitude      = mag_r;
  assign out_crossing_total = total_r;
  assign out_in_cooldown    = cool_r;

endmodule

// File: rtl/core/sgd_checker.sv
// Port-level checker for the shake gesture detector, bound to the top level.
module sgd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_shake_pulse,
  input logic [sgd_pkg::MAG_W-1:0]         out_magnitude,
  input logic [sgd_pkg::CNT_W-1:0]         out_crossing_total,
  input logic                              out_in_cooldown
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shake_pulse)
      && $stable(out_magnitude) && $stable(out_crossing_total) && $stable(out_in_cooldown))
    else $error("stalled result changed");

  // An ignored sample never completes a shake
  a_pulse_not_cool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_shake_pulse && out_in_cooldown))
    else $error("shake flagged during cooldown");

  // A completed shake clears the crossing count
  a_pulse_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shake_pulse |-> out_crossing_total == '0)
    else $error("crossing count not cleared on shake");

  // With the result register empty the pipeline always has room
  a_room_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind shake_gesture_detector sgd_checker u_sgd_checker (.*);

// File: tb/sv/shake_gesture_detector_tb.sv
// Self-checking testbench for the shake gesture detector: directed table, random phases.
`timescale 1ns / 1ps

module shake_gesture_detector_tb;

  // Index that maps to no register; writes to it must leave the block untouched
  localparam logic [sgd_pkg::IDX_W-1:0] NO_SUCH_REG = 3'd7;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 163;
  localparam int unsigned MAX_MAG     = 98304;
  localparam int unsigned AXIS_MAX    = 32768;

  // One result transaction, field by field
  typedef struct packed {
    logic                      shake;
    logic [sgd_pkg::MAG_W-1:0] magnitude;
    logic [sgd_pkg::CNT_W-1:0] crossings;
    logic                      cooldown;
  } shake_result_t;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

  // One row of the directed table: either a sample or a register write
  typedef struct {
    row_kind_t                  kind;
    logic [sgd_pkg::IDX_W-1:0]  idx;
    logic [sgd_pkg::CFG_W-1:0]  wdata;
    logic [sgd_pkg::AXIS_W-1:0] ax, ay, az;
    logic [sgd_pkg::TIME_W-1:0] stamp;
    bit                         pinned;
    shake_result_t              want;
  } stim_row_t;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         cfg_we      = 1'b0;
  logic [sgd_pkg::IDX_W-1:0]    cfg_index   = '0;
  logic [sgd_pkg::CFG_W-1:0]    cfg_wdata   = '0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [sgd_pkg::AXIS_W-1:0]   in_accel_x  = '0;
  logic [sgd_pkg::AXIS_W-1:0]   in_accel_y  = '0;
  logic [sgd_pkg::AXIS_W-1:0]   in_accel_z  = '0;
  logic [sgd_pkg::TIME_W-1:0]   in_time_ms  = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic                         out_shake_pulse;
  logic [sgd_pkg::MAG_W-1:0]    out_magnitude;
  logic [sgd_pkg::CNT_W-1:0]    out_crossing_total;
  logic                         out_in_cooldown;

  // Typed-in expectation travelling with the sample that is on the bus
  bit                           row_pinned = 1'b0;
  shake_result_t                row_expect = '0;

  int unsigned                  send_idle_pct = 0;
  int unsigned                  stall_pct     = 0;
  int unsigned                  error_count   = 0;

  // Detector shadow: register copies and tracking state
  logic [sgd_pkg::MAG_W-1:0]    thr_high    = sgd_pkg::RST_HIGH_THRESHOLD;
  logic [sgd_pkg::MAG_W-1:0]    thr_low     = sgd_pkg::RST_LOW_THRESHOLD;
  logic [sgd_pkg::TIME_W-1:0]   gap_limit   = sgd_pkg::RST_MAX_CROSSING_GAP_MS;
  logic [sgd_pkg::CNT_W-1:0]    need_count  = sgd_pkg::RST_REQUIRED_CROSSINGS;
  logic [sgd_pkg::TIME_W-1:0]   quiet_ms    = sgd_pkg::RST_COOLDOWN_MS;
  logic                         hyst_above  = 1'b0;
  logic [sgd_pkg::CNT_W-1:0]    cross_count = '0;
  logic [sgd_pkg::TIME_W-1:0]   cross_stamp = '0;
  logic [sgd_pkg::TIME_W-1:0]   shake_stamp = '0;

  // Timestamp walker for the random part
  logic [sgd_pkg::TIME_W-1:0]   walk_ms = '0;

  shake_result_t                pending_results [$];
  stim_row_t                    directed_rows [$];

  // Register settings per random phase, extremes among them
  sgd_pkg::cfg_t phase_settings [PHASES] = '{
    '{20000, 12000, 300,          4,   1000},
    '{0,     98304, 32'hFFFF_FFFF, 255, 0},
    '{98304, 0,     0,            2,   50},
    '{30000, 5000,  150,          3,   200},
    '{5000,  30000, 500,          6,   100},
    '{20000, 12000, 300,          255, 400},
    '{40000, 20000, 1000,         2,   2000},
    '{10000, 9000,  64,           1,   32'hFFFF_FFFF}
  };

  shake_gesture_detector u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_accel_x         (in_accel_x),
    .in_accel_y         (in_accel_y),
    .in_accel_z         (in_accel_z),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shake_pulse    (out_shake_pulse),
    .out_magnitude      (out_magnitude),
    .out_crossing_total (out_crossing_total),
    .out_in_cooldown    (out_in_cooldown)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Absolute value of a 16-bit two's complement axis; the most negative code gives 32768
  function automatic logic [sgd_pkg::MAG_W-1:0] axis_abs(logic [sgd_pkg::AXIS_W-1:0] v);
    return v[sgd_pkg::AXIS_W-1] ? sgd_pkg::MAG_W'(17'h10000 - {1'b0, v}) : {1'b0, v};
  endfunction

  // Advance the shadow detector by one sample and return the result it reports
  function automatic shake_result_t track_sample(logic [sgd_pkg::AXIS_W-1:0] ax, ay, az,
                                                 logic [sgd_pkg::TIME_W-1:0] now);
    shake_result_t r;
    r.magnitude = axis_abs(ax) + axis_abs(ay) + axis_abs(az);
    r.shake     = 1'b0;
    r.cooldown  = 1'b0;
    if (sgd_pkg::TIME_W'(now - shake_stamp) < quiet_ms) begin
      // Inside the cooldown window: report, but leave all state alone
      r.cooldown = 1'b1;
    end else begin
      if (sgd_pkg::TIME_W'(now - cross_stamp) > gap_limit) cross_count = '0;
      if (!hyst_above && r.magnitude > thr_high) begin
        hyst_above  = 1'b1;
        cross_count = cross_count + 1'b1;
        cross_stamp = now;
      end else if (hyst_above && r.magnitude < thr_low) begin
        hyst_above  = 1'b0;
        cross_count = cross_count + 1'b1;
        cross_stamp = now;
      end
      if (cross_count >= need_count) begin
        r.shake     = 1'b1;
        shake_stamp = now;
        cross_count = '0;
      end
    end
    r.crossings = cross_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("%0t ns MISMATCH: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result(shake_result_t seen, shake_result_t want);
    if (seen.shake !== want.shake)
      report_mismatch($sformatf("shake_pulse got %0b want %0b", seen.shake, want.shake));
    if (seen.magnitude !== want.magnitude)
      report_mismatch($sformatf("magnitude got %0d want %0d", seen.magnitude, want.magnitude));
    if (seen.crossings !== want.crossings)
      report_mismatch($sformatf("crossing_total got %0d want %0d",
                                seen.crossings, want.crossings));
    if (seen.cooldown !== want.cooldown)
      report_mismatch($sformatf("in_cooldown got %0b want %0b", seen.cooldown, want.cooldown));
  endtask

  // Watch both channels at the rising edge. Inputs were set at the falling edge
  // and the block updates its registers after this edge, so both sides are stable.
  always @(posedge clk) begin : watch
    shake_result_t want;
    shake_result_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        // Always step the shadow; a typed-in expectation replaces its answer
        want = track_sample(in_accel_x, in_accel_y, in_accel_z, in_time_ms);
        if (row_pinned) want = row_expect;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        seen.shake     = out_shake_pulse;
        seen.magnitude = out_magnitude;
        seen.crossings = out_crossing_total;
        seen.cooldown  = out_in_cooldown;
        if (pending_results.size() == 0)
          report_mismatch("result transaction with no sample outstanding");
        else
          check_result(seen, pending_results.pop_front());
      end
    end
  end

  // Receiver: stall at random at the configured rate
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one sample after a random number of idle cycles and hold it until
  // accepted. Called and returning at a falling edge, with valid left high so a
  // back-to-back sample costs no bubble.
  task automatic send_sample(logic [sgd_pkg::AXIS_W-1:0] ax, ay, az,
                             logic [sgd_pkg::TIME_W-1:0] stamp,
                             bit pinned, shake_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_time_ms <= stamp;
    row_pinned <= pinned;
    row_expect <= want;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write one register; only called with the block idle
  task automatic write_register(logic [sgd_pkg::IDX_W-1:0] idx,
                                logic [sgd_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      sgd_pkg::CFG_HIGH_THRESHOLD:      thr_high   = data[sgd_pkg::MAG_W-1:0];
      sgd_pkg::CFG_LOW_THRESHOLD:       thr_low    = data[sgd_pkg::MAG_W-1:0];
      sgd_pkg::CFG_MAX_CROSSING_GAP_MS: gap_limit  = data;
      sgd_pkg::CFG_REQUIRED_CROSSINGS:  need_count = data[sgd_pkg::CNT_W-1:0];
      sgd_pkg::CFG_COOLDOWN_MS:         quiet_ms   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(sgd_pkg::cfg_t s);
    wait_results_drained();
    write_register(sgd_pkg::CFG_HIGH_THRESHOLD,      sgd_pkg::CFG_W'(s.high_threshold));
    write_register(sgd_pkg::CFG_LOW_THRESHOLD,       sgd_pkg::CFG_W'(s.low_threshold));
    write_register(sgd_pkg::CFG_MAX_CROSSING_GAP_MS, s.max_crossing_gap_ms);
    write_register(sgd_pkg::CFG_REQUIRED_CROSSINGS,  sgd_pkg::CFG_W'(s.required_crossings));
    write_register(sgd_pkg::CFG_COOLDOWN_MS,         s.cooldown_ms);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stim_row_t sample_row(int x, int y, int z,
                                           logic [sgd_pkg::TIME_W-1:0] t);
    stim_row_t r;
    r.kind   = ROW_SAMPLE;
    r.idx    = '0;
    r.wdata  = '0;
    r.ax     = sgd_pkg::AXIS_W'(x);
    r.ay     = sgd_pkg::AXIS_W'(y);
    r.az     = sgd_pkg::AXIS_W'(z);
    r.stamp  = t;
    r.pinned = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t pinned_row(int x, int y, int z,
                                           logic [sgd_pkg::TIME_W-1:0] t,
                                           bit shake, int mag, int cnt, bit cool);
    stim_row_t r;
    r                = sample_row(x, y, z, t);
    r.pinned         = 1'b1;
    r.want.shake     = shake;
    r.want.magnitude = sgd_pkg::MAG_W'(mag);
    r.want.crossings = sgd_pkg::CNT_W'(cnt);
    r.want.cooldown  = cool;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [sgd_pkg::IDX_W-1:0] idx,
                                          logic [sgd_pkg::CFG_W-1:0] data);
    stim_row_t r;
    r       = sample_row(0, 0, 0, '0);
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.wdata = data;
    return r;
  endfunction

  // Signed axis code of a given absolute value, sign chosen at random
  function automatic logic [sgd_pkg::AXIS_W-1:0] to_axis(int v);
    if (v == AXIS_MAX) return 16'h8000;
    return $urandom_range(0, 1) ? sgd_pkg::AXIS_W'(-v) : sgd_pkg::AXIS_W'(v);
  endfunction

  // Mostly well-formed shake traffic: timestamps that walk forward in steps that
  // keep crossings alive, magnitudes aimed at the next hysteresis crossing. The
  // rest hits window boundaries exactly, jumps the clock anywhere, or is noise.
  task automatic pick_random_sample(output logic [sgd_pkg::AXIS_W-1:0] ax, ay, az,
                                    output logic [sgd_pkg::TIME_W-1:0] stamp);
    int roll;
    int m;
    int a;
    int b;
    int rem;
    roll = $urandom_range(0, 99);
    if (roll < 70)
      walk_ms += $urandom_range(0, (gap_limit > 400) ? 400 : gap_limit);
    else if (roll < 85)
      walk_ms += $urandom_range(0, 3000);
    else if (roll < 90)
      walk_ms = shake_stamp + quiet_ms - $urandom_range(0, 1);
    else if (roll < 95)
      walk_ms = cross_stamp + gap_limit + $urandom_range(0, 1);
    else
      walk_ms = $urandom;
    stamp = walk_ms;

    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      ax = sgd_pkg::AXIS_W'($urandom);
      ay = sgd_pkg::AXIS_W'($urandom);
      az = sgd_pkg::AXIS_W'($urandom);
      return;
    end
    if (roll < 88) begin
      if (hyst_above)
        m = (thr_low == 0) ? 0 : $urandom_range(0, thr_low - 1);
      else
        m = (thr_high >= MAX_MAG) ? MAX_MAG : $urandom_range(thr_high + 1, MAX_MAG);
    end else if (roll < 95) begin
      // Land right on or next to a threshold
      case ($urandom_range(0, 3))
        0:       m = thr_high;
        1:       m = int'(thr_high) + 1;
        2:       m = thr_low;
        default: m = int'(thr_low) - 1;
      endcase
      if (m < 0) m = 0;
      if (m > MAX_MAG) m = MAX_MAG;
    end else begin
      m = $urandom_range(0, MAX_MAG);
    end

    // Split the magnitude over three axes, none above 32768
    a   = $urandom_range((m > 2 * AXIS_MAX) ? m - 2 * AXIS_MAX : 0,
                         (m < AXIS_MAX) ? m : AXIS_MAX);
    rem = m - a;
    b   = $urandom_range((rem > AXIS_MAX) ? rem - AXIS_MAX : 0,
                         (rem < AXIS_MAX) ? rem : AXIS_MAX);
    ax  = to_axis(a);
    ay  = to_axis(b);
    az  = to_axis(rem - b);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [sgd_pkg::AXIS_W-1:0] ax, ay, az;
    logic [sgd_pkg::TIME_W-1:0] stamp;

    // Directed rows run at reset settings until the writes near the end.
    // Typed-in rows are the ones whose result is obvious: cooldown hits and
    // the zero-required shake.
    directed_rows = '{
      // startup cooldown: last shake time resets to zero
      pinned_row(0, 0, 0, 0, 0, 0, 0, 1),
      pinned_row(-32768, -32768, -32768, 999, 0, 98304, 0, 1),
      // first live sample, full-scale positive: upward crossing
      sample_row(32767, 32767, 32767, 1000),
      sample_row(0, 0, 0, 1100),
      sample_row(-32768, 0, 0, 1200),
      // fourth crossing completes the shake
      sample_row(1, -1, 0, 1300),
      // ignored during cooldown, magnitude still reported
      pinned_row(32767, 32767, 32767, 1500, 0, 98301, 0, 1),
      // cooldown just over; stale count clears
      sample_row(0, 0, 0, 2300),
      // thresholds are strict: equal is no crossing, one beyond is
      sample_row(20000, 0, 0, 2400),
      sample_row(20001, 0, 0, 2500),
      sample_row(12000, 0, 0, 2600),
      // gap one over the limit clears, then the crossing counts from zero
      sample_row(11999, 0, 0, 2801),
      // gap exactly at the limit keeps the count
      sample_row(30000, 0, 0, 3101),
      // shake just before the clock wraps, then cooldown across the wrap
      sample_row(25000, 0, 0, 32'hFFFF_FF00),
      sample_row(0, 0, 0, 32'hFFFF_FF10),
      sample_row(25000, 0, 0, 32'hFFFF_FF20),
      sample_row(0, 0, 0, 32'hFFFF_FF30),
      sample_row(25000, 0, 0, 32'hFFFF_FF40),
      pinned_row(0, 0, 0, 32'h0000_0100, 0, 0, 0, 1),
      sample_row(0, 0, 0, 32'h0000_0400),
      // required lowered to the current count: next live sample shakes
      write_row(sgd_pkg::CFG_REQUIRED_CROSSINGS, 1),
      write_row(NO_SUCH_REG, 32'hFFFF_FFFF),
      sample_row(0, 0, 0, 32'h0000_0500),
      // zero required and no cooldown: every sample shakes
      write_row(sgd_pkg::CFG_REQUIRED_CROSSINGS, 0),
      write_row(sgd_pkg::CFG_COOLDOWN_MS, 0),
      pinned_row(0, 0, 0, 32'h0000_0501, 1, 0, 0, 0)
    };

    // Hold reset from time zero, release at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_results_drained();
        write_register(directed_rows[i].idx, directed_rows[i].wdata);
      end else begin
        send_sample(directed_rows[i].ax, directed_rows[i].ay, directed_rows[i].az,
                    directed_rows[i].stamp, directed_rows[i].pinned, directed_rows[i].want);
      end
    end
    walk_ms = 32'h0000_0600;

    // Random phases: new register settings each time, idle pattern rotating
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      apply_settings(phase_settings[ph]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 74; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through, let the pipeline empty completely before going on
        if (n == PHASE_ITEMS / 2) wait_results_drained();
        pick_random_sample(ax, ay, az, stamp);
        send_sample(ax, ay, az, stamp, 1'b0, '0);
      end
    end

    // Drain, then keep watching for stray results before the verdict
    wait_results_drained();
    repeat (8) @(negedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
